>>> rtl/wsts_pkg.sv
// Shared types and constants of the work-stealing task scheduler.
// No dependencies; imported by the interfaces, the top level and the bench.
`timescale 1ns / 1ps
`default_nettype none
package wsts_pkg;

	localparam int WORKERS_DEF      = 4;
	localparam int QUEUE_DEPTH_DEF  = 256;
	localparam int INJECT_DEPTH_DEF = 16;
	localparam int STEAL_LIMIT_DEF  = 256;
	localparam int TASKS_DEF        = 256;

	localparam int CMD_W  = 2;
	localparam int WID_W  = 2;
	localparam int TASK_W = 8;
	localparam int STAT_W = 2;
	localparam int ACT_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_SPAWN = 2'd0,
		CMD_LWAKE = 2'd1,
		CMD_XWAKE = 2'd2,
		CMD_FIND  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_QFULL = 2'd1,
		STAT_IFULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_IPOP,
		ST_MVRD,
		ST_MVWR,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

>>> rtl/wsts_if.sv
// Channel interfaces of the scheduler: command words, result words, config writes.
// Depends on wsts_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface wsts_req_if
	import wsts_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [WID_W-1:0]  worker_id;
	logic [TASK_W-1:0] task_id;
	modport source (output valid, command, worker_id, task_id, input ready);
	modport sink (input valid, command, worker_id, task_id, output ready);
endinterface

interface wsts_rsp_if
	import wsts_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              found;
	logic [TASK_W-1:0] chosen_task;
	logic [STAT_W-1:0] status;
	logic              local_pending;
	modport source (output valid, found, chosen_task, status, local_pending, input ready);
	modport sink (input valid, found, chosen_task, status, local_pending, output ready);
endinterface

interface wsts_cfg_if
	import wsts_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] active_workers;
	modport source (output valid, active_workers, input ready);
	modport sink (input valid, active_workers, output ready);
endinterface
`default_nettype wire

>>> rtl/wsts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wsts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/work_stealing_task_scheduler.sv
// Top level of the work-stealing task scheduler.
// Depends on wsts_pkg, the interfaces in wsts_if and wsts_ram.
//
// One command word is taken at a time. Spawn, local wake and external wake pass
// through the execute and finish states; find-work goes from execute to finish when
// the next slot hits, passes a pop state when it pops the own queue or an injection
// FIFO, and for a steal of k tasks passes a read state and a write state per moved
// task: the read fetches the sibling entry, the write hands the first task to the
// worker and puts each later one in the own queue. After reset a clearing pass wipes
// every home table entry; no command is taken until it ends, config writes are taken
// throughout. A finished result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module work_stealing_task_scheduler
	import wsts_pkg::*;
#(
	parameter int WORKERS      = WORKERS_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int INJECT_DEPTH = INJECT_DEPTH_DEF,
	parameter int STEAL_LIMIT  = STEAL_LIMIT_DEF,
	parameter int TASKS        = TASKS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	wsts_req_if.sink   req,
	wsts_rsp_if.source rsp,
	wsts_cfg_if.sink   cfg
);

	localparam int WI_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int CW0  = $clog2(2 * WORKERS + 1);
	localparam int CW   = ((CW0 > ACT_W) ? CW0 : ACT_W) + 1;
	localparam int QPW  = $clog2(2 * QUEUE_DEPTH);
	localparam int QAW  = $clog2(WORKERS * QUEUE_DEPTH);
	localparam int IPW  = $clog2(2 * INJECT_DEPTH);
	localparam int IAW  = (WORKERS * INJECT_DEPTH > 1) ? $clog2(WORKERS * INJECT_DEPTH) : 1;
	localparam int HAW  = $clog2(TASKS);
	localparam int HW   = WI_W + 1;

	function automatic logic [QPW-1:0] qcnt(input logic [QPW-1:0] t, input logic [QPW-1:0] h);
		logic [QPW:0] d;
		d = {1'b0, t} - {1'b0, h};
		if (t < h) d = d + (QPW+1)'(2 * QUEUE_DEPTH);
		return d[QPW-1:0];
	endfunction

	function automatic logic [QPW-1:0] qinc(input logic [QPW-1:0] p);
		return (p == QPW'(2 * QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [QAW-1:0] qaddr(input logic [WI_W-1:0] wk, input logic [QPW-1:0] p);
		logic [QPW-1:0] x;
		x = (p >= QPW'(QUEUE_DEPTH)) ? p - QPW'(QUEUE_DEPTH) : p;
		return QAW'(int'(wk) * QUEUE_DEPTH + int'(x));
	endfunction

	function automatic logic [IPW-1:0] icnt(input logic [IPW-1:0] t, input logic [IPW-1:0] h);
		logic [IPW:0] d;
		d = {1'b0, t} - {1'b0, h};
		if (t < h) d = d + (IPW+1)'(2 * INJECT_DEPTH);
		return d[IPW-1:0];
	endfunction

	function automatic logic [IPW-1:0] iinc(input logic [IPW-1:0] p);
		return (p == IPW'(2 * INJECT_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IAW-1:0] iaddr(input logic [WI_W-1:0] wk, input logic [IPW-1:0] p);
		logic [IPW-1:0] x;
		x = (p >= IPW'(INJECT_DEPTH)) ? p - IPW'(INJECT_DEPTH) : p;
		return IAW'(int'(wk) * INJECT_DEPTH + int'(x));
	endfunction

	// Task handle modulo TASKS by restoring subtraction, one bit a step.
	function automatic logic [HAW-1:0] modt(input logic [TASK_W-1:0] t);
		int r;
		r = int'(t);
		for (int k = TASK_W - 1; k >= 0; k--) begin
			if (r >= (TASKS << k)) r = r - (TASKS << k);
		end
		return HAW'(r);
	endfunction

	// control and queue state
	state_t            state_q, state_d;
	logic [HAW-1:0]    clr_q;
	logic [ACT_W-1:0]  act_q;
	logic [QPW-1:0]    qh_q [WORKERS];
	logic [QPW-1:0]    qt_q [WORKERS];
	logic [IPW-1:0]    ih_q [WORKERS];
	logic [IPW-1:0]    it_q [WORKERS];
	logic              slot_v_q [WORKERS];
	logic [TASK_W-1:0] slot_t_q [WORKERS];
	logic              ov_q;

	// per-command registers
	cmd_t              cmd_q;
	logic [WID_W-1:0]  w_q;
	logic [TASK_W-1:0] t_q;
	logic [CW-1:0]     n_q;
	logic              found_q, found_d;
	logic [TASK_W-1:0] chosen_q, chosen_d;
	status_t           stat_q, stat_d;
	logic [QPW-1:0]    rem_q, rem_d;
	logic              first_q, first_d;
	logic [WI_W-1:0]   v_q, v_d;

	// output register
	logic              o_found_q;
	logic [TASK_W-1:0] o_task_q;
	status_t           o_stat_q;
	logic              o_pend_q;

	// strobes
	logic              ld_in, ld_out, pend_d, slot_set, slot_clr;
	logic              qt_inc, qh_inc, it_inc, ih_inc;
	logic [WI_W-1:0]   qt_sel, qh_sel, it_sel, ih_sel, dst;
	logic              q_we, i_we, h_we;
	logic [QAW-1:0]    q_waddr, q_raddr;
	logic [IAW-1:0]    i_waddr, i_raddr;
	logic [HAW-1:0]    h_waddr;
	logic [TASK_W-1:0] q_wdata, i_wdata, q_rdata, i_rdata;
	logic [HW-1:0]     h_wdata, h_rdata;

	logic [WI_W-1:0]   wi;
	logic              act_ok;
	logic [CW-1:0]     n_in;
	logic [WORKERS-1:0] qne, ine;
	logic              sq_hit, si_hit;
	logic [WI_W-1:0]   sq_v, si_v;
	logic [CW-1:0]     sv;
	logic [QPW:0]      khalf;

	assign wi     = WI_W'(w_q);
	assign act_ok = CW'(w_q) < n_q;
	assign n_in   = (act_q == '0) ? CW'(1) :
		((CW'(act_q) > CW'(WORKERS)) ? CW'(WORKERS) : CW'(act_q));

	always_comb begin
		for (int i = 0; i < WORKERS; i++) begin
			qne[i] = qt_q[i] != qh_q[i];
			ine[i] = it_q[i] != ih_q[i];
		end
	end

	// first non-empty sibling, scanning upward from the worker, wrapping at n
	always_comb begin
		sq_hit = 1'b0;
		si_hit = 1'b0;
		sq_v   = '0;
		si_v   = '0;
		sv     = '0;
		for (int i = 1; i < WORKERS; i++) begin
			sv = CW'(w_q) + CW'(i);
			if (sv >= n_q) sv = sv - n_q;
			if (CW'(i) < n_q) begin
				if (!sq_hit && qne[WI_W'(sv)]) begin
					sq_hit = 1'b1;
					sq_v   = WI_W'(sv);
				end
				if (!si_hit && ine[WI_W'(sv)]) begin
					si_hit = 1'b1;
					si_v   = WI_W'(sv);
				end
			end
		end
	end

	assign khalf = ({1'b0, qcnt(qt_q[sq_v], qh_q[sq_v])} + 1'b1) >> 1;

	always_comb begin
		state_d  = state_q;
		found_d  = found_q;
		chosen_d = chosen_q;
		stat_d   = stat_q;
		rem_d    = rem_q;
		first_d  = first_q;
		v_d      = v_q;
		ld_in    = 1'b0;
		ld_out   = 1'b0;
		slot_set = 1'b0;
		slot_clr = 1'b0;
		qt_inc   = 1'b0;
		qh_inc   = 1'b0;
		it_inc   = 1'b0;
		ih_inc   = 1'b0;
		qt_sel   = wi;
		qh_sel   = wi;
		it_sel   = wi;
		ih_sel   = wi;
		q_we     = 1'b0;
		q_waddr  = '0;
		q_wdata  = '0;
		q_raddr  = '0;
		i_we     = 1'b0;
		i_waddr  = '0;
		i_wdata  = t_q;
		i_raddr  = '0;
		h_we     = 1'b0;
		h_waddr  = '0;
		h_wdata  = '0;
		dst      = '0;
		pend_d   = (cmd_q != CMD_XWAKE) && act_ok && qne[wi];
		case (state_q)
			ST_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
				if (clr_q == HAW'(TASKS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) begin
					ld_in    = 1'b1;
					found_d  = 1'b0;
					chosen_d = '0;
					stat_d   = STAT_OK;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_FIN;
				if (cmd_q == CMD_XWAKE) begin
					// home read was issued at accept
					if (h_rdata[HW-1] && (CW'(h_rdata[WI_W-1:0]) < n_q)) begin
						dst = h_rdata[WI_W-1:0];
					end
					if (icnt(it_q[dst], ih_q[dst]) == IPW'(INJECT_DEPTH)) begin
						stat_d = STAT_IFULL;
					end else begin
						i_we    = 1'b1;
						i_waddr = iaddr(dst, it_q[dst]);
						it_inc  = 1'b1;
						it_sel  = dst;
					end
				end else if (act_ok) begin
					case (cmd_q)
						CMD_SPAWN: begin
							if (qcnt(qt_q[wi], qh_q[wi]) == QPW'(QUEUE_DEPTH)) begin
								stat_d = STAT_QFULL;
							end else begin
								q_we    = 1'b1;
								q_waddr = qaddr(wi, qt_q[wi]);
								q_wdata = t_q;
								qt_inc  = 1'b1;
							end
						end
						CMD_LWAKE: begin
							slot_set = 1'b1;
							if (slot_v_q[wi]) begin
								// displace the old slot task into the queue
								if (qcnt(qt_q[wi], qh_q[wi]) == QPW'(QUEUE_DEPTH)) begin
									stat_d = STAT_QFULL;
								end else begin
									q_we    = 1'b1;
									q_waddr = qaddr(wi, qt_q[wi]);
									q_wdata = slot_t_q[wi];
									qt_inc  = 1'b1;
								end
							end
						end
						CMD_FIND: begin
							if (slot_v_q[wi]) begin
								found_d  = 1'b1;
								chosen_d = slot_t_q[wi];
								slot_clr = 1'b1;
							end else if (qne[wi]) begin
								q_raddr = qaddr(wi, qh_q[wi]);
								qh_inc  = 1'b1;
								state_d = ST_POP;
							end else if (sq_hit) begin
								v_d     = sq_v;
								first_d = 1'b1;
								if (32'(khalf) > STEAL_LIMIT) rem_d = QPW'(STEAL_LIMIT);
								else rem_d = QPW'(khalf);
								state_d = ST_MVRD;
							end else if (ine[wi]) begin
								i_raddr = iaddr(wi, ih_q[wi]);
								ih_inc  = 1'b1;
								state_d = ST_IPOP;
							end else if (si_hit) begin
								i_raddr = iaddr(si_v, ih_q[si_v]);
								ih_inc  = 1'b1;
								ih_sel  = si_v;
								state_d = ST_IPOP;
							end
						end
						default: ;
					endcase
				end
			end
			ST_POP: begin
				found_d  = 1'b1;
				chosen_d = q_rdata;
				state_d  = ST_FIN;
			end
			ST_IPOP: begin
				found_d  = 1'b1;
				chosen_d = i_rdata;
				state_d  = ST_FIN;
			end
			ST_MVRD: begin
				q_raddr = qaddr(v_q, qh_q[v_q]);
				qh_inc  = 1'b1;
				qh_sel  = v_q;
				rem_d   = rem_q - 1'b1;
				state_d = ST_MVWR;
			end
			ST_MVWR: begin
				if (first_q) begin
					// first stolen task goes to the worker
					found_d  = 1'b1;
					chosen_d = q_rdata;
					first_d  = 1'b0;
				end else if (qcnt(qt_q[wi], qh_q[wi]) == QPW'(QUEUE_DEPTH)) begin
					stat_d = STAT_QFULL;
				end else begin
					q_we    = 1'b1;
					q_waddr = qaddr(wi, qt_q[wi]);
					q_wdata = q_rdata;
					qt_inc  = 1'b1;
				end
				state_d = (rem_q == '0) ? ST_FIN : ST_MVRD;
			end
			ST_FIN: begin
				if (!ov_q || rsp.ready) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
					if (found_q) begin
						h_we    = 1'b1;
						h_waddr = modt(chosen_q);
						h_wdata = {1'b1, wi};
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			act_q <= ACT_W'(1);
			ov_q  <= 1'b0;
			for (int i = 0; i < WORKERS; i++) begin
				qh_q[i]     <= '0;
				qt_q[i]     <= '0;
				ih_q[i]     <= '0;
				it_q[i]     <= '0;
				slot_v_q[i] <= 1'b0;
			end
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg.valid) act_q <= cfg.active_workers;
			if (ld_out) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
			for (int i = 0; i < WORKERS; i++) begin
				if (qt_inc && qt_sel == WI_W'(i)) qt_q[i] <= qinc(qt_q[i]);
				if (qh_inc && qh_sel == WI_W'(i)) qh_q[i] <= qinc(qh_q[i]);
				if (it_inc && it_sel == WI_W'(i)) it_q[i] <= iinc(it_q[i]);
				if (ih_inc && ih_sel == WI_W'(i)) ih_q[i] <= iinc(ih_q[i]);
			end
			if (slot_set) slot_v_q[wi] <= 1'b1;
			if (slot_clr) slot_v_q[wi] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_in) begin
			cmd_q <= cmd_t'(req.command);
			w_q   <= req.worker_id;
			t_q   <= req.task_id;
			n_q   <= n_in;
		end
		if (slot_set) slot_t_q[wi] <= t_q;
		found_q  <= found_d;
		chosen_q <= chosen_d;
		stat_q   <= stat_d;
		rem_q    <= rem_d;
		first_q  <= first_d;
		v_q      <= v_d;
		if (ld_out) begin
			o_found_q <= found_q;
			o_task_q  <= chosen_q;
			o_stat_q  <= stat_q;
			o_pend_q  <= pend_d;
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = ov_q;
	assign rsp.found         = o_found_q;
	assign rsp.chosen_task   = o_task_q;
	assign rsp.status        = o_stat_q;
	assign rsp.local_pending = o_pend_q;

	wsts_ram #(.WIDTH(TASK_W), .DEPTH(WORKERS * QUEUE_DEPTH)) u_qram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	wsts_ram #(.WIDTH(TASK_W), .DEPTH(WORKERS * INJECT_DEPTH)) u_iram (
		.clk   (clk),
		.we    (i_we),
		.waddr (i_waddr),
		.wdata (i_wdata),
		.raddr (i_raddr),
		.rdata (i_rdata)
	);

	// home table is read with the incoming word, ready for the external wake
	wsts_ram #(.WIDTH(HW), .DEPTH(TASKS)) u_hram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (modt(req.task_id)),
		.rdata (h_rdata)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req.ready)
		else $error("command taken during clearing pass");

	a_empty_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.chosen_task == '0)
		else $error("task reported without a find");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		q_we |-> qcnt(qt_q[qt_sel], qh_q[qt_sel]) != QPW'(QUEUE_DEPTH))
		else $error("write into a full task queue");

	a_steal_loops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MVWR && rem_q != '0 |=> state_q == ST_MVRD)
		else $error("steal batch cut short");

endmodule
`default_nettype wire

>>> bench/work_stealing_task_scheduler_tb.sv
// Self-checking bench for the work-stealing task scheduler.
// Depends on wsts_pkg, the wsts_if interfaces and the scheduler RTL.
`timescale 1ns / 1ps
module work_stealing_task_scheduler_tb;
	import wsts_pkg::*;

	typedef struct packed {
		logic             found;
		logic [TASK_W-1:0] chosen;
		logic [STAT_W-1:0] status;
		logic             pending;
	} sched_result_t;

	logic clk;
	logic arst_n;

	wsts_req_if req ();
	wsts_rsp_if rsp ();
	wsts_cfg_if cfg ();

	work_stealing_task_scheduler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// shadow scheduler state
	logic [TASK_W-1:0] shadow_queue [WORKERS_DEF][QUEUE_DEPTH_DEF];
	int                q_rd [WORKERS_DEF];
	int                q_wr [WORKERS_DEF];
	logic              slot_full [WORKERS_DEF];
	logic [TASK_W-1:0] slot_task [WORKERS_DEF];
	logic [TASK_W-1:0] shadow_inject [WORKERS_DEF][INJECT_DEPTH_DEF];
	int                i_rd [WORKERS_DEF];
	int                i_wr [WORKERS_DEF];
	logic              home_known [TASKS_DEF];
	int                home_of [TASKS_DEF];
	logic [ACT_W-1:0]  active_reg;

	sched_result_t expected_results [$];
	int  errors;
	int  words_sent;
	int  results_seen;
	int  steals;
	int  drops;
	int  hold_cycles;
	int  burst_left;
	bit  sender_smooth;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Timeout at %0t", $realtime);
		$display("Some tests failed");
		$finish;
	end

	function automatic int q_used(int w);
		return (q_wr[w] - q_rd[w] + 2 * QUEUE_DEPTH_DEF) % (2 * QUEUE_DEPTH_DEF);
	endfunction

	function automatic int i_used(int w);
		return (i_wr[w] - i_rd[w] + 2 * INJECT_DEPTH_DEF) % (2 * INJECT_DEPTH_DEF);
	endfunction

	function automatic bit q_put(int w, logic [TASK_W-1:0] t);
		if (q_used(w) >= QUEUE_DEPTH_DEF) return 1'b0;
		shadow_queue[w][q_wr[w] % QUEUE_DEPTH_DEF] = t;
		q_wr[w] = (q_wr[w] + 1) % (2 * QUEUE_DEPTH_DEF);
		return 1'b1;
	endfunction

	function automatic logic [TASK_W-1:0] q_take(int w);
		logic [TASK_W-1:0] t;
		t = shadow_queue[w][q_rd[w] % QUEUE_DEPTH_DEF];
		q_rd[w] = (q_rd[w] + 1) % (2 * QUEUE_DEPTH_DEF);
		return t;
	endfunction

	function automatic logic [TASK_W-1:0] i_take(int w);
		logic [TASK_W-1:0] t;
		t = shadow_inject[w][i_rd[w] % INJECT_DEPTH_DEF];
		i_rd[w] = (i_rd[w] + 1) % (2 * INJECT_DEPTH_DEF);
		return t;
	endfunction

	task automatic schedule_model(input cmd_t c, input int w, input logic [TASK_W-1:0] t);
		sched_result_t r;
		int n, dst, v, k;
		bit hit;
		r = '0;
		hit = 1'b0;
		n = (active_reg == 0) ? 1 : ((active_reg > WORKERS_DEF) ? WORKERS_DEF : active_reg);
		if (c == CMD_XWAKE) begin
			dst = (home_known[t] && home_of[t] < n) ? home_of[t] : 0;
			if (i_used(dst) >= INJECT_DEPTH_DEF) begin
				r.status = STAT_IFULL;
			end else begin
				shadow_inject[dst][i_wr[dst] % INJECT_DEPTH_DEF] = t;
				i_wr[dst] = (i_wr[dst] + 1) % (2 * INJECT_DEPTH_DEF);
			end
		end else if (w < n) begin
			if (c == CMD_SPAWN) begin
				if (!q_put(w, t)) r.status = STAT_QFULL;
			end else if (c == CMD_LWAKE) begin
				if (slot_full[w] && !q_put(w, slot_task[w])) r.status = STAT_QFULL;
				slot_full[w] = 1'b1;
				slot_task[w] = t;
			end else begin
				if (slot_full[w]) begin
					r.chosen = slot_task[w];
					slot_full[w] = 1'b0;
					hit = 1'b1;
				end else if (q_used(w) > 0) begin
					r.chosen = q_take(w);
					hit = 1'b1;
				end
				for (int i = 1; i < n && !hit; i++) begin
					v = (w + i) % n;
					if (q_used(v) > 0) begin
						k = (q_used(v) + 1) / 2;
						if (k > STEAL_LIMIT_DEF) k = STEAL_LIMIT_DEF;
						r.chosen = q_take(v);
						for (int j = 1; j < k; j++)
							if (!q_put(w, q_take(v))) r.status = STAT_QFULL;
						hit = 1'b1;
						steals++;
					end
				end
				if (!hit && i_used(w) > 0) begin
					r.chosen = i_take(w);
					hit = 1'b1;
				end
				for (int i = 1; i < n && !hit; i++) begin
					v = (w + i) % n;
					if (i_used(v) > 0) begin
						r.chosen = i_take(v);
						hit = 1'b1;
					end
				end
				if (hit) begin
					r.found = 1'b1;
					home_known[r.chosen] = 1'b1;
					home_of[r.chosen] = w;
				end
			end
			r.pending = q_used(w) > 0;
		end
		if (r.status != STAT_OK) drops++;
		expected_results.push_back(r);
	endtask

	// called at a falling edge; returns at a falling edge with valid still high
	// when the next word follows without a gap
	task automatic send_word(input cmd_t c, input int w, input logic [TASK_W-1:0] t);
		int gap;
		req.valid     = 1'b1;
		req.command   = c;
		req.worker_id = w[WID_W-1:0];
		req.task_id   = t;
		do @(posedge clk); while (!req.ready);
		schedule_model(c, w, t);
		words_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = sender_smooth ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				req.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		req.valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_active(input logic [ACT_W-1:0] value);
		wait_idle();
		cfg.valid          = 1'b1;
		cfg.active_workers = value;
		do @(posedge clk); while (!cfg.ready);
		active_reg = value;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// result sink: random stall runs, free-flowing runs, and long hold-offs
	initial begin : result_sink
		int run;
		bit stall;
		run = 0;
		stall = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp.ready = 1'b0;
			end else begin
				if (run == 0) begin
					stall = ($urandom_range(0, 2) == 0);
					run = stall ? $urandom_range(1, 5) : $urandom_range(1, 40);
				end
				run--;
				rsp.ready = !stall;
			end
		end
	end

	always @(posedge clk) begin
		sched_result_t exp_r, got_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			got_r = '{rsp.found, rsp.chosen_task, rsp.status, rsp.local_pending};
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got_r);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got_r.found !== exp_r.found) begin
					$display("%0t: found exp %h got %h", $realtime, exp_r.found, got_r.found);
					errors++;
				end
				if (got_r.chosen !== exp_r.chosen) begin
					$display("%0t: chosen_task exp %h got %h", $realtime, exp_r.chosen,
						got_r.chosen);
					errors++;
				end
				if (got_r.status !== exp_r.status) begin
					$display("%0t: status exp %h got %h", $realtime, exp_r.status,
						got_r.status);
					errors++;
				end
				if (got_r.pending !== exp_r.pending) begin
					$display("%0t: local_pending exp %h got %h", $realtime, exp_r.pending,
						got_r.pending);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		set_active(3'd4);
		send_word(CMD_FIND, 0, 8'h00);          // nothing anywhere
		send_word(CMD_SPAWN, 0, 8'h00);
		send_word(CMD_SPAWN, 0, 8'hFF);
		send_word(CMD_LWAKE, 1, 8'h05);
		send_word(CMD_LWAKE, 1, 8'h06);         // displace 0x05 into the queue
		send_word(CMD_FIND, 1, 8'hAA);          // next slot
		send_word(CMD_FIND, 1, 8'h55);          // own queue
		send_word(CMD_FIND, 3, 8'h00);          // steal from worker 0 after wrap
		send_word(CMD_XWAKE, 2, 8'h06);         // home is worker 1
		send_word(CMD_XWAKE, 0, 8'h77);         // no home, goes to worker 0
		send_word(CMD_FIND, 2, 8'h00);          // steals 0xFF from worker 0
		send_word(CMD_FIND, 1, 8'h00);
		send_word(CMD_FIND, 3, 8'h00);          // sibling injection FIFO, takes 0x77 from worker 0
		set_active(3'd2);
		send_word(CMD_SPAWN, 3, 8'h12);         // inactive worker
		send_word(CMD_FIND, 2, 8'h00);
		send_word(CMD_XWAKE, 1, 8'hFF);         // home 2 out of range
		send_word(CMD_FIND, 1, 8'h00);
		set_active(3'd0);
		send_word(CMD_LWAKE, 1, 8'h33);
		send_word(CMD_FIND, 0, 8'h00);
		set_active(3'd7);
		send_word(CMD_LWAKE, 3, 8'h44);
		send_word(CMD_FIND, 3, 8'h00);
	endtask

	task automatic test_inject_full();
		set_active(3'd1);
		for (int i = 0; i < 20; i++)
			send_word(CMD_XWAKE, $urandom_range(0, 3), 8'($urandom_range(128, 255)));
		for (int i = 0; i < 18; i++) send_word(CMD_FIND, 0, 8'($urandom));
	endtask

	task automatic test_queue_full_and_big_steal();
		set_active(3'd1);
		for (int i = 0; i < 262; i++) send_word(CMD_SPAWN, 0, 8'($urandom));
		send_word(CMD_LWAKE, 0, 8'h01);
		send_word(CMD_LWAKE, 0, 8'h02);         // displaced task dropped
		set_active(3'd4);
		send_word(CMD_FIND, 1, 8'h00);          // steals 128
		send_word(CMD_FIND, 2, 8'h00);
		send_word(CMD_FIND, 3, 8'h00);
	endtask

	task automatic test_backpressure();
		set_active(3'd4);
		sender_smooth = 1'b1;
		hold_cycles = 400;
		for (int i = 0; i < 30; i++)
			send_word(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 3), 8'($urandom));
		sender_smooth = 1'b0;
	endtask

	task automatic test_random();
		int pick, w;
		cmd_t c;
		logic [TASK_W-1:0] t;
		for (int phase = 0; phase < 10; phase++) begin
			set_active(phase == 0 ? 3'd0 : (phase == 1 ? 3'd7 : 3'($urandom_range(1, 4))));
			sender_smooth = (phase % 4 == 3);
			for (int i = 0; i < 105; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) c = CMD_SPAWN;
				else if (pick < 50) c = CMD_LWAKE;
				else if (pick < 65) c = CMD_XWAKE;
				else c = CMD_FIND;
				w = $urandom_range(0, 3);
				// reuse a small pool of handles so recorded homes come into play
				t = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
				send_word(c, w, t);
			end
		end
		sender_smooth = 1'b0;
	endtask

	initial begin
		errors = 0;
		words_sent = 0;
		results_seen = 0;
		steals = 0;
		drops = 0;
		hold_cycles = 0;
		burst_left = 0;
		sender_smooth = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_SPAWN;
		req.worker_id = '0;
		req.task_id = '0;
		cfg.valid = 1'b0;
		cfg.active_workers = 3'd1;
		active_reg = 3'd1;
		for (int w = 0; w < WORKERS_DEF; w++) begin
			q_rd[w] = 0;
			q_wr[w] = 0;
			i_rd[w] = 0;
			i_wr[w] = 0;
			slot_full[w] = 1'b0;
			slot_task[w] = '0;
		end
		for (int i = 0; i < TASKS_DEF; i++) begin
			home_known[i] = 1'b0;
			home_of[i] = 0;
		end
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_inject_full();
		test_queue_full_and_big_steal();
		test_backpressure();
		test_random();

		wait_idle();
		repeat (20) @(negedge clk);
		$display("Sent %0d command words, checked %0d results", words_sent, results_seen);
		$display("Covered %0d steals and %0d dropped tasks", steals, drops);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> work_stealing_task_scheduler.f
rtl/wsts_pkg.sv
rtl/wsts_if.sv
rtl/wsts_ram.sv
rtl/work_stealing_task_scheduler.sv
bench/work_stealing_task_scheduler_tb.sv
